// ----- rtl/egd_pkg.sv -----
// Shared types and constants for the elevator group dispatcher.
`default_nettype none

package egd_pkg;

  localparam int CAR_COUNT   = 8;
  localparam int FLOOR_COUNT = 16;

  localparam int CAR_IDX_W = (CAR_COUNT > 1) ? $clog2(CAR_COUNT) : 1;
  localparam int FLOOR_W   = 4;
  localparam int STOPS_W   = 8;
  localparam int CARNUM_W  = 7;
  localparam int STATUS_W  = 3;
  localparam int OUTCAR_W  = 3;

  typedef logic [CAR_IDX_W-1:0] car_idx_t;
  typedef logic [FLOOR_W-1:0]   floor_t;
  typedef logic [STOPS_W-1:0]   stops_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ASSIGNED = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NO_CAR   = 3'd2,
    ST_STORED   = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // One car's table entry
  typedef struct packed {
    stops_t stops;
    floor_t floor;
    logic   dir;
  } car_entry_t;

  // Running best candidates of all three passes, handed from cell to cell
  typedef struct packed {
    logic     valid;
    floor_t   floor;
    logic     dir;
    logic     idle_ok;
    car_idx_t idle_car;
    floor_t   idle_gap;
    logic     same_ok;
    car_idx_t same_car;
    floor_t   same_gap;
    logic     busy_ok;
    car_idx_t busy_car;
    stops_t   busy_stops;
  } sweep_t;

endpackage

`default_nettype wire

// ----- rtl/egd_cell.sv -----
// One car cell: holds the car's entry and folds it into the passing sweep record.
`default_nettype none

module egd_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire egd_pkg::car_idx_t idx,
  input  wire logic              wr_en,
  input  wire egd_pkg::car_entry_t wr_entry,
  input  wire egd_pkg::sweep_t   rec_in,
  output egd_pkg::sweep_t        rec_out
);

  egd_pkg::car_entry_t entry;
  egd_pkg::sweep_t     rec_next;
  egd_pkg::floor_t     gap;
  logic                busy;
  logic                ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    rec_next = rec_in;
    busy     = (entry.stops != '0);
    gap      = (entry.floor > rec_in.floor) ? (entry.floor - rec_in.floor)
                                            : (rec_in.floor - entry.floor);
    // car is heading the call's way and has not yet passed it
    ahead    = (entry.dir == rec_in.dir) &&
               (rec_in.dir ? (entry.floor < rec_in.floor) : (entry.floor > rec_in.floor));

    // <= so that a later, higher-numbered car wins a tie
    if (!busy && (!rec_in.idle_ok || gap <= rec_in.idle_gap)) begin
      rec_next.idle_ok  = 1'b1;
      rec_next.idle_car = idx;
      rec_next.idle_gap = gap;
    end
    if (busy && ahead && (!rec_in.same_ok || gap <= rec_in.same_gap)) begin
      rec_next.same_ok  = 1'b1;
      rec_next.same_car = idx;
      rec_next.same_gap = gap;
    end
    if (busy && (!rec_in.busy_ok || entry.stops <= rec_in.busy_stops)) begin
      rec_next.busy_ok    = 1'b1;
      rec_next.busy_car   = idx;
      rec_next.busy_stops = entry.stops;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/elevator_group_dispatcher.sv -----
// Top level: stream ports, car status writes, call checks and the chain of car cells.
`default_nettype none

// Hall-call dispatcher for a group of CAR_COUNT cars. Each car has a cell holding its
// last reported floor, direction and pending-stop count (all zero after reset). A car
// status beat, or a hall call that is rejected, gives its result in the cycle after the
// beat is taken. A valid hall call launches a record that walks the row of cells, one
// cell per cycle, collecting the idle, same-direction and busy candidates in one sweep,
// and its result is loaded into the output register when the record leaves the last cell.
// One item is worked on at a time: s_tready stays low in reset, during a sweep and while
// an untaken result sits in the output register. The saver-mode bit is written through
// the cfg port, which is ready whenever reset is low, and should only change while the
// block is idle.

module elevator_group_dispatcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] call_floor, [4] call_direction, [11:5] car_number, [15:12] car_floor,
  // [16] car_direction, [24:17] car_stop_count, [25] car_emergency, [31:26] zero
  input  wire logic [31:0] s_tdata,
  // [0] req_type
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] assigned_car, [6:3] assigned_floor, [7] zero
  output logic [7:0]       m_tdata,
  // [2:0] status
  output logic [2:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  localparam int N = egd_pkg::CAR_COUNT;

  egd_pkg::state_t     state, state_next;
  logic                saver_en;

  logic                req_type;
  egd_pkg::floor_t     call_floor;
  logic                call_direction;
  logic [egd_pkg::CARNUM_W-1:0] car_number;
  egd_pkg::car_entry_t wr_entry;
  logic                car_emergency;

  logic                accept;
  logic                call_bad;
  logic                car_ok;
  logic                launch;
  logic                imm_load;
  egd_pkg::status_t    imm_status;

  egd_pkg::sweep_t     rec [N+1];
  logic [N-1:0]        wr_en;

  egd_pkg::status_t    res_status;
  egd_pkg::car_idx_t   res_car;

  logic                out_load;
  egd_pkg::status_t    out_status;
  logic [egd_pkg::OUTCAR_W-1:0] out_car;
  egd_pkg::floor_t     out_floor;
  egd_pkg::floor_t     scan_floor;

  // field unpacking; entry is {stops, floor, dir}
  assign req_type       = s_tuser[0];
  assign call_floor     = s_tdata[3:0];
  assign call_direction = s_tdata[4];
  assign car_number     = s_tdata[11:5];
  assign wr_entry       = {s_tdata[24:17], s_tdata[15:12], s_tdata[16]};
  assign car_emergency  = s_tdata[25];

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      saver_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      saver_en <= cfg_data;
    end
  end

  assign s_tready = !rst && (state == egd_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign call_bad = (32'(call_floor) >= egd_pkg::FLOOR_COUNT) ||
                    (call_floor == '0 && !call_direction) ||
                    (32'(call_floor) == egd_pkg::FLOOR_COUNT - 1 && call_direction);
  assign car_ok   = !car_emergency && (32'(car_number) < N);
  assign launch   = accept && !req_type && !call_bad;
  assign imm_load = accept && !launch;

  always_comb begin
    if (!req_type) begin
      imm_status = egd_pkg::ST_INVALID;
    end else if (car_ok) begin
      imm_status = egd_pkg::ST_STORED;
    end else begin
      imm_status = egd_pkg::ST_IGNORED;
    end
  end

  // sweep record entering the first cell
  always_comb begin
    rec[0]       = '0;
    rec[0].valid = launch;
    rec[0].floor = call_floor;
    rec[0].dir   = call_direction;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign wr_en[i] = accept && req_type && car_ok &&
                      (car_number == egd_pkg::CARNUM_W'(i));

    egd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (egd_pkg::CAR_IDX_W'(i)),
      .wr_en    (wr_en[i]),
      .wr_entry (wr_entry),
      .rec_in   (rec[i]),
      .rec_out  (rec[i+1])
    );
  end

  // pass order picks the winner from the finished sweep
  always_comb begin
    res_status = egd_pkg::ST_ASSIGNED;
    res_car    = '0;
    if (saver_en && rec[N].same_ok) begin
      res_car = rec[N].same_car;
    end else if (rec[N].idle_ok) begin
      res_car = rec[N].idle_car;
    end else if (rec[N].same_ok) begin
      res_car = rec[N].same_car;
    end else if (rec[N].busy_ok) begin
      res_car = rec[N].busy_car;
    end else begin
      res_status = egd_pkg::ST_NO_CAR;
    end
  end

  assign scan_floor = rec[N].floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      egd_pkg::S_IDLE: begin
        if (launch) begin
          state_next = egd_pkg::S_SCAN;
        end
        out_load = imm_load;
      end
      egd_pkg::S_SCAN: begin
        if (rec[N].valid) begin
          state_next = egd_pkg::S_IDLE;
          out_load   = 1'b1;
        end
      end
      default: begin
        state_next = egd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == egd_pkg::S_SCAN) begin
        out_status <= res_status;
        out_car    <= (res_status == egd_pkg::ST_ASSIGNED) ? egd_pkg::OUTCAR_W'(res_car) : '0;
        out_floor  <= (res_status == egd_pkg::ST_ASSIGNED) ? scan_floor : '0;
      end else begin
        out_status <= imm_status;
        out_car    <= '0;
        out_floor  <= '0;
      end
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {1'b0, out_floor, out_car};

endmodule

`default_nettype wire

// ----- rtl/egd_checker.sv -----
// Port-level checks for the dispatcher, bound to the top level.
`default_nettype none

module egd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [2:0]  m_tuser
);

  // a result beat held back must stay offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // only an assignment carries a car and a floor
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != egd_pkg::ST_ASSIGNED |-> m_tdata == 8'd0)
    else $error("non-assigned result carries data");

  // down call at the bottom floor is rejected at once
  a_bottom: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == 1'b0 && s_tdata[4:0] == 5'd0
    |=> m_tvalid && m_tuser == egd_pkg::ST_INVALID)
    else $error("bottom-floor down call not rejected");

  // an emergency update is ignored at once
  a_emerg: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] && s_tdata[25]
    |=> m_tvalid && m_tuser == egd_pkg::ST_IGNORED)
    else $error("emergency update not ignored");

endmodule

bind elevator_group_dispatcher egd_checker u_egd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
